// ----- design/btt_pkg.sv -----
// Shared constants, codes and entry layout for the bounded transposition table.
package btt_pkg;

	// Table size; must be a power of two so that slot and key map by their low bits.
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int KEY_W   = 64;
	localparam int VALUE_W = 32;
	localparam int DEPTH_W = 8;
	localparam int BOUND_W = 2;
	localparam int OP_W    = 2;
	localparam int SLOT_W  = 10;

	localparam logic [OP_W-1:0] OP_PROBE  = 2'd0;
	localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
	localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd1;
	localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;

	localparam logic signed [VALUE_W-1:0] UNKNOWN_RESET = 32'sh8000_0000;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
	} info_t;

	localparam int INFO_W = $bits(info_t);

endpackage

// ----- design/btt_ram.sv -----
// Simple dual-port synchronous RAM with a registered read port.
module btt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/btt_resolve.sv -----
// Probe decision: key and depth match, then bound kind against the alpha-beta window.
module btt_resolve import btt_pkg::*; (
	input  logic [KEY_W-1:0]          stored_key,
	input  info_t                     stored_info,
	input  logic [KEY_W-1:0]          req_key,
	input  logic [DEPTH_W-1:0]        req_depth,
	input  logic signed [VALUE_W-1:0] alpha,
	input  logic signed [VALUE_W-1:0] beta,
	input  logic signed [VALUE_W-1:0] unknown_value,
	output logic                      hit,
	output logic signed [VALUE_W-1:0] value
);

	logic match;

	assign match = (stored_key == req_key) && (stored_info.depth == req_depth);

	always_comb begin
		hit   = 1'b0;
		value = unknown_value;
		if (match) begin
			case (stored_info.bound)
				BOUND_EXACT: begin
					hit   = 1'b1;
					value = stored_info.value;
				end
				BOUND_UPPER: begin
					if (stored_info.value <= alpha) begin
						hit   = 1'b1;
						value = alpha;
					end
				end
				BOUND_LOWER: begin
					if (stored_info.value >= beta) begin
						hit   = 1'b1;
						value = beta;
					end
				end
				default: begin
					hit   = 1'b0;
					value = unknown_value;
				end
			endcase
		end
	end

endmodule

// ----- design/bounded_transposition_table.sv -----
// A probe, record or update is read from both memories on acceptance; its result is registered in the execute state.
// No new request is taken until the last result is registered; the key and entry memories serve one request at a time.
// A held result stalls the next request in its execute cycle until the receiver takes the result.
// A clear walks the key memory one entry a cycle; its result is registered in the execute state after the walk.
// Reset: a sweep over all TABLE_ENTRIES entries zeroes both memories, with s_tready low meanwhile.
// Reset sets unknown_value to the most negative 32-bit value; the config port is always ready.
module bounded_transposition_table import btt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// position_key[63:0], score[95:64], search_depth[103:96], bound_kind[105:104],
	// alpha[137:106], beta[169:138], slot[179:170], zero[183:180]
	input  logic [183:0] s_tdata,
	// op[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result_value[31:0]
	output logic [31:0]  m_tdata,
	// hit[0]
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] ptr_q;

	logic [OP_W-1:0]           op_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [VALUE_W-1:0] score_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic signed [VALUE_W-1:0] alpha_q;
	logic signed [VALUE_W-1:0] beta_q;
	logic [IDX_W-1:0]          idx_q;

	logic signed [VALUE_W-1:0] unknown_q;
	logic                      hit_q;
	logic signed [VALUE_W-1:0] res_q;
	logic                      out_valid_q;

	logic [OP_W-1:0]           in_op;
	logic [KEY_W-1:0]          in_key;
	logic signed [VALUE_W-1:0] in_score;
	logic [DEPTH_W-1:0]        in_depth;
	logic [BOUND_W-1:0]        in_bound;
	logic signed [VALUE_W-1:0] in_alpha;
	logic signed [VALUE_W-1:0] in_beta;
	logic [SLOT_W-1:0]         in_slot;
	logic [IDX_W-1:0]          in_idx;

	logic s_fire;
	logic out_free;
	logic sweep_last;

	logic               key_we;
	logic [IDX_W-1:0]   key_waddr;
	logic [KEY_W-1:0]   key_wdata;
	logic [KEY_W-1:0]   key_rdata;
	logic               info_we;
	logic [IDX_W-1:0]   info_waddr;
	info_t              info_wdata;
	logic [INFO_W-1:0]  info_rdata;
	info_t              info_rd;
	logic               mem_re;

	logic                      probe_hit;
	logic signed [VALUE_W-1:0] probe_value;

	assign in_op    = s_tuser;
	assign in_key   = s_tdata[63:0];
	assign in_score = s_tdata[95:64];
	assign in_depth = s_tdata[103:96];
	assign in_bound = s_tdata[105:104];
	assign in_alpha = s_tdata[137:106];
	assign in_beta  = s_tdata[169:138];
	assign in_slot  = s_tdata[179:170];

	// Update addresses by the key, everything else by the slot; both reduce by their low bits.
	assign in_idx = (in_op == OP_UPDATE) ? IDX_W'(in_key) : IDX_W'(in_slot);

	assign s_tready   = (state_q == ST_IDLE);
	assign s_fire     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign sweep_last = (ptr_q == LAST_IDX);
	assign cfg_ready  = 1'b1;

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = res_q;
	assign m_tuser[0] = hit_q;

	assign mem_re  = s_fire;
	assign info_rd = info_t'(info_rdata);

	always_comb begin
		key_we    = 1'b0;
		key_waddr = in_idx;
		key_wdata = in_key;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				key_we    = 1'b1;
				key_waddr = ptr_q;
				key_wdata = '0;
			end
			ST_IDLE: begin
				key_we = s_fire && ((in_op == OP_RECORD) || (in_op == OP_UPDATE));
			end
			default: begin
				key_we = 1'b0;
			end
		endcase
	end

	// Update keeps the stored bound kind, so its info write waits for the read of the entry.
	always_comb begin
		info_we          = 1'b0;
		info_waddr       = in_idx;
		info_wdata.value = in_score;
		info_wdata.depth = in_depth;
		info_wdata.bound = in_bound;
		case (state_q)
			ST_INIT: begin
				info_we    = 1'b1;
				info_waddr = ptr_q;
				info_wdata = '0;
			end
			ST_IDLE: begin
				info_we = s_fire && (in_op == OP_RECORD);
			end
			ST_EXEC: begin
				info_we          = out_free && (op_q == OP_UPDATE);
				info_waddr       = idx_q;
				info_wdata.value = score_q;
				info_wdata.depth = depth_q;
				info_wdata.bound = info_rd.bound;
			end
			default: begin
				info_we = 1'b0;
			end
		endcase
	end

	btt_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (mem_re),
		.raddr(in_idx),
		.rdata(key_rdata)
	);

	btt_ram #(
		.WIDTH(INFO_W),
		.DEPTH(TABLE_ENTRIES)
	) u_info_ram (
		.clk  (clk),
		.we   (info_we),
		.waddr(info_waddr),
		.wdata(info_wdata),
		.re   (mem_re),
		.raddr(in_idx),
		.rdata(info_rdata)
	);

	btt_resolve u_resolve (
		.stored_key   (key_rdata),
		.stored_info  (info_rd),
		.req_key      (key_q),
		.req_depth    (depth_q),
		.alpha        (alpha_q),
		.beta         (beta_q),
		.unknown_value(unknown_q),
		.hit          (probe_hit),
		.value        (probe_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
			unknown_q   <= UNKNOWN_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unknown_q <= cfg_data;
			end
			// A new result may replace the one taken at the same edge.
			if ((state_q == ST_EXEC) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						ptr_q   <= '0;
						state_q <= (in_op == OP_CLEAR) ? ST_CLEAR : ST_EXEC;
					end
				end
				ST_CLEAR: begin
					ptr_q <= ptr_q + IDX_W'(1);
					if (sweep_last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_q    <= in_op;
			key_q   <= in_key;
			score_q <= in_score;
			depth_q <= in_depth;
			alpha_q <= in_alpha;
			beta_q  <= in_beta;
			idx_q   <= in_idx;
		end
		if ((state_q == ST_EXEC) && out_free) begin
			case (op_q)
				OP_PROBE: begin
					hit_q <= probe_hit;
					res_q <= probe_value;
				end
				OP_UPDATE: begin
					hit_q <= 1'b0;
					res_q <= score_q;
				end
				default: begin
					hit_q <= 1'b0;
					res_q <= '0;
				end
			endcase
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the bounded transposition table: directed and random requests checked against a model.
`timescale 1ns / 100ps

module tb_top;
	import btt_pkg::*;

	localparam logic [BOUND_W-1:0] BOUND_INVALID = 2'd3;
	localparam int RECEIVER_HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT_CYCLES   = 50000;
	localparam int REPORT_LIMIT         = 100;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [BOUND_W-1:0]        bound;
		logic signed [VALUE_W-1:0] alpha;
		logic signed [VALUE_W-1:0] beta;
		logic [SLOT_W-1:0]         slot;
	} tt_request_t;

	typedef struct {
		logic                      hit;
		logic signed [VALUE_W-1:0] value;
	} tt_answer_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	// position_key[63:0], score[95:64], search_depth[103:96], bound_kind[105:104],
	// alpha[137:106], beta[169:138], slot[179:170], zero[183:180]
	logic [183:0] s_tdata   = '0;
	// op[1:0]
	logic [1:0]   s_tuser   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	// result_value[31:0]
	logic [31:0]  m_tdata;
	// hit[0]
	logic [0:0]   m_tuser;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [31:0]  cfg_data  = '0;

	// Shadow copy of the table and the register.
	logic [KEY_W-1:0]          tt_key   [TABLE_ENTRIES];
	logic signed [VALUE_W-1:0] tt_value [TABLE_ENTRIES];
	logic [DEPTH_W-1:0]        tt_depth [TABLE_ENTRIES];
	logic [BOUND_W-1:0]        tt_bound [TABLE_ENTRIES];
	logic signed [VALUE_W-1:0] unknown_now;

	tt_answer_t expected_answers [$];
	tt_answer_t front_answer;
	int         recent_slots [$];

	int error_count   = 0;
	int n_sent        = 0;
	int n_checked     = 0;
	int n_hits        = 0;
	int n_clears      = 0;
	int n_config      = 0;
	bit steady_flow   = 1'b0;
	int hold_requests = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	bounded_transposition_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic void reset_table_copy();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tt_key[i]   = '0;
			tt_value[i] = '0;
			tt_depth[i] = '0;
			tt_bound[i] = '0;
		end
		unknown_now = UNKNOWN_RESET;
	endfunction

	// Applies one request to the shadow table and returns the answer it must give.
	function automatic tt_answer_t predict_answer(tt_request_t rq);
		tt_answer_t  ans;
		int unsigned at;
		ans.hit   = 1'b0;
		ans.value = '0;
		case (rq.op)
			OP_PROBE: begin
				at = rq.slot % TABLE_ENTRIES;
				ans.value = unknown_now;
				if (tt_key[at] == rq.key && tt_depth[at] == rq.depth) begin
					if (tt_bound[at] == BOUND_EXACT) begin
						ans.hit   = 1'b1;
						ans.value = tt_value[at];
					end else if (tt_bound[at] == BOUND_UPPER && tt_value[at] <= rq.alpha) begin
						ans.hit   = 1'b1;
						ans.value = rq.alpha;
					end else if (tt_bound[at] == BOUND_LOWER && tt_value[at] >= rq.beta) begin
						ans.hit   = 1'b1;
						ans.value = rq.beta;
					end
				end
			end
			OP_RECORD: begin
				at = rq.slot % TABLE_ENTRIES;
				tt_key[at]   = rq.key;
				tt_value[at] = rq.score;
				tt_depth[at] = rq.depth;
				tt_bound[at] = rq.bound;
			end
			OP_UPDATE: begin
				at = 32'(rq.key % 64'(TABLE_ENTRIES));
				tt_key[at]   = rq.key;
				tt_value[at] = rq.score;
				tt_depth[at] = rq.depth;
				ans.value    = rq.score;
			end
			default: begin
				// Clear only wipes the keys; values, depths and bounds stay.
				for (int i = 0; i < TABLE_ENTRIES; i++)
					tt_key[i] = '0;
				n_clears++;
			end
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("tb: mismatch in %s at result %0d: expected %h, got %h",
				what, n_checked, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", '0, m_tdata);
			end else begin
				front_answer = expected_answers.pop_front();
				if (m_tuser[0] !== front_answer.hit)
					report_mismatch("hit", 32'(front_answer.hit), 32'(m_tuser[0]));
				if (m_tdata !== front_answer.value)
					report_mismatch("result_value", front_answer.value, m_tdata);
				if (front_answer.hit)
					n_hits++;
				n_checked++;
			end
		end
	end

	// Result side: random stalls, plus a long hold whenever a test asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = RECEIVER_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!steady_flow && $urandom_range(99) < 24) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_request(tt_request_t rq);
		while (!steady_flow && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= {4'b0, rq.slot, rq.beta, rq.alpha, rq.bound, rq.depth, rq.score, rq.key};
		s_tuser  <= rq.op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		expected_answers.push_back(predict_answer(rq));
		n_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_unknown_value(logic signed [VALUE_W-1:0] v);
		wait_drained();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		unknown_now = v;
		n_config++;
	endtask

	function automatic tt_request_t request_of(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
		logic signed [VALUE_W-1:0] score, logic [DEPTH_W-1:0] depth,
		logic [BOUND_W-1:0] bound, logic signed [VALUE_W-1:0] alpha,
		logic signed [VALUE_W-1:0] beta, logic [SLOT_W-1:0] slot);
		tt_request_t rq;
		rq.op    = op;
		rq.key   = key;
		rq.score = score;
		rq.depth = depth;
		rq.bound = bound;
		rq.alpha = alpha;
		rq.beta  = beta;
		rq.slot  = slot;
		return rq;
	endfunction

	function automatic logic signed [VALUE_W-1:0] random_score();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return int'($urandom_range(8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_slot();
		if (recent_slots.size() > 0 && $urandom_range(99) < 60)
			return recent_slots[$urandom_range(recent_slots.size() - 1)];
		return $urandom_range(TABLE_ENTRIES - 1);
	endfunction

	function automatic void note_slot(int s);
		recent_slots.push_back(s);
		if (recent_slots.size() > 48)
			void'(recent_slots.pop_front());
	endfunction

	// Probes lead the mix and are mostly aimed at live entries so that hits and window edges are common.
	function automatic tt_request_t make_random_request();
		tt_request_t rq;
		int          pick;
		int          s;
		pick     = $urandom_range(99);
		rq.op    = pick < 44 ? OP_PROBE : pick < 70 ? OP_RECORD : pick < 97 ? OP_UPDATE : OP_CLEAR;
		case ($urandom_range(3))
			0: rq.key = 64'($urandom_range(3));
			1: rq.key = {32'($urandom_range(3)), 32'($urandom)};
			default: rq.key = {$urandom, $urandom};
		endcase
		rq.score = random_score();
		rq.depth = 8'($urandom_range(99) < 50 ? $urandom_range(3) : $urandom_range(255));
		rq.bound = $urandom_range(99) < 10 ? BOUND_INVALID : BOUND_W'($urandom_range(2));
		rq.alpha = random_score();
		rq.beta  = random_score();
		rq.slot  = SLOT_W'($urandom_range(TABLE_ENTRIES - 1));
		case (rq.op)
			OP_PROBE: begin
				if ($urandom_range(99) < 70) begin
					s = pick_slot();
					rq.slot  = SLOT_W'(s);
					rq.key   = tt_key[s];
					rq.depth = tt_depth[s];
					if ($urandom_range(99) < 15)
						rq.depth = rq.depth ^ (8'd1 << $urandom_range(7));
					if ($urandom_range(99) < 70) begin
						rq.alpha = tt_value[s] + (int'($urandom_range(4)) - 2);
						rq.beta  = tt_value[s] + (int'($urandom_range(4)) - 2);
					end
				end
			end
			OP_RECORD: begin
				rq.slot = SLOT_W'(pick_slot());
				note_slot(int'(rq.slot));
			end
			OP_UPDATE: begin
				if ($urandom_range(99) < 50)
					rq.key[IDX_W-1:0] = IDX_W'(pick_slot());
				note_slot(int'(rq.key[IDX_W-1:0]));
			end
			default: ;
		endcase
		return rq;
	endfunction

	task automatic send_random_requests(int count);
		for (int i = 0; i < count; i++)
			send_request(make_random_request());
	endtask

	task automatic test_directed_cases();
		logic [KEY_W-1:0] far_key;
		logic [KEY_W-1:0] low_key;
		far_key = '1;
		low_key = 64'hABCD_0000_0000_0007;
		// After reset every entry is key 0, depth 0, exact, value 0.
		send_request(request_of(OP_PROBE, '0, '0, '0, '0, '0, '0, 10'd0));
		send_request(request_of(OP_PROBE, 64'd1, '0, '0, '0, '0, '0, 10'd1023));
		send_request(request_of(OP_RECORD, far_key, 32'sh7fff_ffff, 8'd255, BOUND_EXACT,
			'0, '0, 10'd1023));
		send_request(request_of(OP_PROBE, far_key, '0, 8'd255, '0, '0, '0, 10'd1023));
		send_request(request_of(OP_PROBE, far_key, '0, 8'd254, '0, '0, '0, 10'd1023));
		// Upper bound: hits only when the stored value is at or below alpha.
		send_request(request_of(OP_RECORD, 64'h8000_0000_0000_0005, 32'sh8000_0000, '0,
			BOUND_UPPER, '0, '0, 10'd5));
		send_request(request_of(OP_PROBE, 64'h8000_0000_0000_0005, '0, '0, '0,
			32'sh8000_0000, '0, 10'd5));
		send_request(request_of(OP_RECORD, 64'd6, 32'sd100, 8'd3, BOUND_UPPER, '0, '0, 10'd6));
		send_request(request_of(OP_PROBE, 64'd6, '0, 8'd3, '0, 32'sd99, '0, 10'd6));
		send_request(request_of(OP_PROBE, 64'd6, '0, 8'd3, '0, 32'sd100, '0, 10'd6));
		// Lower bound: hits only when the stored value is at or above beta.
		send_request(request_of(OP_RECORD, 64'd7, -32'sd50, 8'd9, BOUND_LOWER, '0, '0, 10'd7));
		send_request(request_of(OP_PROBE, 64'd7, '0, 8'd9, '0, '0, -32'sd49, 10'd7));
		send_request(request_of(OP_PROBE, 64'd7, '0, 8'd9, '0, '0, -32'sd50, 10'd7));
		send_request(request_of(OP_PROBE, 64'd7, '0, 8'd9, '0, '0, 32'sh8000_0000, 10'd7));
		// A bound kind of three is stored but never answers.
		send_request(request_of(OP_RECORD, 64'd8, '0, 8'd1, BOUND_INVALID, '0, '0, 10'd8));
		send_request(request_of(OP_PROBE, 64'd8, '0, 8'd1, '0, 32'sh7fff_ffff,
			32'sh8000_0000, 10'd8));
		// Update lands on key mod table size and keeps the old lower bound kind.
		send_request(request_of(OP_UPDATE, low_key, 32'sd123, 8'd9, BOUND_EXACT, '0, '0, '0));
		send_request(request_of(OP_PROBE, low_key, '0, 8'd9, '0, '0, 32'sd123, 10'd7));
		send_request(request_of(OP_PROBE, low_key, '0, 8'd9, '0, '0, 32'sd124, 10'd7));
		send_request(request_of(OP_UPDATE, far_key, -32'sd1, 8'd255, BOUND_LOWER, '0, '0, '0));
		send_request(request_of(OP_PROBE, far_key, '0, 8'd255, '0, '0, 32'sh7fff_ffff,
			10'd1023));
		// After a clear, key 0 still finds the old value and kind.
		send_request(request_of(OP_CLEAR, far_key, '1, '1, BOUND_INVALID, '1, '1, '1));
		send_request(request_of(OP_PROBE, far_key, '0, 8'd255, '0, '0, '0, 10'd1023));
		send_request(request_of(OP_PROBE, '0, '0, 8'd255, '0, '0, '0, 10'd1023));
		write_unknown_value(32'sh7fff_ffff);
		send_request(request_of(OP_PROBE, 64'd99, '0, '0, '0, '0, '0, 10'd512));
		wait_drained();
	endtask

	task automatic test_unknown_value_settings();
		logic signed [VALUE_W-1:0] settings [4];
		settings[0] = 32'sh8000_0000;
		settings[1] = '0;
		settings[2] = 32'sh7fff_ffff;
		settings[3] = $urandom;
		for (int p = 0; p < 4; p++) begin
			write_unknown_value(settings[p]);
			send_random_requests(160);
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		// The receiver holds off while requests keep coming until the input stalls.
		hold_requests++;
		send_random_requests(80);
		wait_drained();
		send_random_requests(70);
		wait_drained();
	endtask

	task automatic test_full_rate_stream();
		steady_flow = 1'b1;
		send_random_requests(150);
		wait_drained();
		steady_flow = 1'b0;
	endtask

	initial begin
		int         waited;
		tt_answer_t left_answer;
		reset_table_copy();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_unknown_value_settings();
		test_output_backpressure();
		test_full_rate_stream();
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_answers.size() != 0 && waited < DRAIN_LIMIT_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		while (expected_answers.size() != 0) begin
			left_answer = expected_answers.pop_front();
			report_mismatch("missing result", left_answer.value, 'x);
		end
		$display("tb: %0d requests sent, %0d results checked, %0d probe hits, %0d clears",
			n_sent, n_checked, n_hits, n_clears);
		$display("tb: %0d unknown_value writes, one long output hold, one full-rate stretch",
			n_config);
		if (error_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/btt_pkg.sv
design/btt_ram.sv
design/btt_resolve.sv
design/bounded_transposition_table.sv
sim/tb_top.sv
